// ----- src/skbs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skbs_pkg
// Shared constants, types and key normalization for the sorted key search.
// ----------------------------------------------------------------------------
package skbs_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_CHARS   = 8;

    localparam int KEY_W   = 64;
    localparam int FIELD_W = 6;
    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = ((IDX_W > FIELD_W) ? IDX_W : FIELD_W) + 2;

    localparam int ENTRY_LSB   = 0;
    localparam int KEY_LSB     = ENTRY_LSB + FIELD_W;
    localparam int FIRST_LSB   = KEY_LSB + KEY_W;
    localparam int LAST_LSB    = FIRST_LSB + FIELD_W;
    localparam int IN_FIELDS_W = LAST_LSB + FIELD_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((FIELD_W + 7) / 8) * 8;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic accept;
        logic step;
        logic load_out;
    } skbs_cmd_t;

    typedef struct packed {
        logic is_search;
        logic range_live;
        logic key_eq;
    } skbs_sts_t;

    function automatic logic [KEY_W-1:0] normalize_key(input logic [KEY_W-1:0] text);
        logic [KEY_W-1:0] result;
        logic             ended;
        logic [7:0]       ch;
        result = '0;
        ended  = 1'b0;
        for (int i = 0; i < 8; i++) begin
            ch = text[KEY_W-1-8*i -: 8];
            if (ch == 8'd0) begin
                ended = 1'b1;
            end
            if (!ended && (i < KEY_CHARS)) begin
                result[KEY_W-1-8*i -: 8] = ch;
            end
        end
        return result;
    endfunction

endpackage

// ----- src/skbs_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skbs_ctrl
// Sequencer: takes a request, steps the bisection and hands off the result.
// ----------------------------------------------------------------------------
module skbs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  skbs_pkg::skbs_sts_t sts,
    output skbs_pkg::skbs_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;

    always_comb begin
        cmd.accept   = s_tvalid && (state_reg == ST_IDLE);
        cmd.step     = (state_reg == ST_PROBE);
        cmd.load_out = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);
    end

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (sts.is_search && sts.range_live) ? ST_PROBE : ST_DONE;
                end
            end
            ST_PROBE: begin
                if (sts.key_eq || !sts.range_live) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (cmd.load_out) begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("request accepted but sequencer stayed idle");

    a_probe_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PROBE && (sts.key_eq || !sts.range_live)) |=> (state_reg == ST_DONE))
        else $error("search did not finish on match or empty range");

    a_result_handoff: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && (!m_tvalid || m_tready)) |=> (m_tvalid && state_reg == ST_IDLE))
        else $error("finished result not handed to output register");

endmodule

// ----- src/skbs_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skbs_dpath
// Key table, bisection bounds, key compare and result registers.
// ----------------------------------------------------------------------------
module skbs_dpath (
    input  logic                                 aclk,
    input  logic [skbs_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                 s_tuser,
    output logic [skbs_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                 m_tuser,
    input  skbs_pkg::skbs_cmd_t                  cmd,
    output skbs_pkg::skbs_sts_t                  sts
);

    localparam int CW = skbs_pkg::CNT_W;
    localparam int IW = skbs_pkg::IDX_W;
    localparam int FW = skbs_pkg::FIELD_W;
    localparam int KW = skbs_pkg::KEY_W;

    logic [KW-1:0] key_mem [skbs_pkg::TABLE_DEPTH];

    logic [KW-1:0]        key_reg;
    logic [KW-1:0]        rdata_reg;
    logic signed [CW-1:0] low_reg;
    logic signed [CW-1:0] high_reg;
    logic signed [CW-1:0] mid_reg;
    logic                 res_found_reg;
    logic [FW-1:0]        res_pos_reg;
    logic                 out_found_reg;
    logic [FW-1:0]        out_pos_reg;

    logic [FW-1:0]        entry_in;
    logic [FW-1:0]        first_in;
    logic [FW-1:0]        last_in;
    logic [KW-1:0]        key_in;
    logic [CW-1:0]        entry_ext;
    logic signed [CW-1:0] last_ext;
    logic signed [CW-1:0] low_next;
    logic signed [CW-1:0] high_next;
    logic signed [CW-1:0] mid_next;
    logic                 key_lt;
    logic                 key_eq;
    logic                 live;
    logic                 is_search;
    logic                 wr_en;
    logic                 rd_en;

    assign entry_in  = s_tdata[skbs_pkg::ENTRY_LSB +: FW];
    assign key_in    = skbs_pkg::normalize_key(s_tdata[skbs_pkg::KEY_LSB +: KW]);
    assign first_in  = s_tdata[skbs_pkg::FIRST_LSB +: FW];
    assign last_in   = s_tdata[skbs_pkg::LAST_LSB +: FW];
    assign is_search = (s_tuser == skbs_pkg::CMD_SEARCH);
    assign entry_ext = CW'(entry_in);
    assign last_ext  = CW'(last_in);

    assign key_lt = (rdata_reg < key_reg);
    assign key_eq = (rdata_reg == key_reg);

    always_comb begin
        if (cmd.accept) begin
            low_next  = CW'(first_in);
            high_next = (last_ext > CW'(skbs_pkg::TABLE_DEPTH - 1))
                      ? CW'(skbs_pkg::TABLE_DEPTH - 1) : last_ext;
        end else if (key_lt) begin
            low_next  = mid_reg + CW'(1);
            high_next = high_reg;
        end else begin
            low_next  = low_reg;
            high_next = mid_reg - CW'(1);
        end
        live     = (low_next <= high_next) && (high_next >= 0);
        mid_next = (low_next + high_next) >>> 1;
    end

    assign wr_en = cmd.accept && !is_search && (entry_ext < CW'(skbs_pkg::TABLE_DEPTH));
    assign rd_en = ((cmd.accept && is_search) || cmd.step) && live;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[IW'(entry_in)] <= key_in;
        end
        if (rd_en) begin
            rdata_reg <= key_mem[mid_next[IW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            key_reg <= key_in;
        end
        if (cmd.accept || cmd.step) begin
            low_reg       <= low_next;
            high_reg      <= high_next;
            mid_reg       <= mid_next;
            res_found_reg <= cmd.step && key_eq;
            res_pos_reg   <= (cmd.step && key_eq) ? FW'(mid_reg) : '0;
        end
        if (cmd.load_out) begin
            out_found_reg <= res_found_reg;
            out_pos_reg   <= res_pos_reg;
        end
    end

    always_comb begin
        sts.is_search  = is_search;
        sts.range_live = live;
        sts.key_eq     = key_eq;
    end

    assign m_tdata = (skbs_pkg::OUT_TDATA_W)'(out_pos_reg);
    assign m_tuser = out_found_reg;

endmodule

// ----- src/sorted_key_binary_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_binary_search
// Sorted table of 64 eight-character keys with a bisection lookup.
// ----------------------------------------------------------------------------
// Input stream: s_tuser selects the request (0 writes key_text to entry
// entry_index, 1 searches for key_text within [first_index, last_index]).
// The caller keeps the table sorted ascending; keys compare as zero-padded
// unsigned byte strings, first character most significant.
// Output stream: one result per request; m_tuser is found, m_tdata the
// matching position (0 when not found, and for writes).
// Timing: one request at a time. A write passes from acceptance through the
// done state to the output register; a search also steps the probe state,
// at most 7 probes for 64 entries (log2 depth + 1), before the done state.
// Each probe is one registered read of the key table memory followed by the
// compare that picks the next midpoint. s_tready rises again together with
// m_tvalid, as the result is loaded into the output register.
// Stall: the result waits in the output register until m_tready; a finished
// request holds until that register is free. The next request is accepted
// while an earlier result still waits.
// Reset: clears the sequencer and output valid; table contents are undefined
// until written.
// ----------------------------------------------------------------------------
module sorted_key_binary_search (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // entry_index[5:0], key_text[69:6], first_index[75:70], last_index[81:76]
    input  logic [skbs_pkg::IN_TDATA_W-1:0]     s_tdata,
    // command[0]
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // position[5:0]
    output logic [skbs_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // found[0]
    output logic                                m_tuser
);

    skbs_pkg::skbs_cmd_t cmd;
    skbs_pkg::skbs_sts_t sts;

    skbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    skbs_dpath u_dpath (
        .aclk    (aclk),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule
